// ===== rtl/core/nibble_tagged_lz_decompressor_core_macros.svh =====
// assertion helpers used by the core module nltd_back
`ifndef NIBBLE_TAGGED_LZ_DECOMPRESSOR_CORE_MACROS_SVH
`define NIBBLE_TAGGED_LZ_DECOMPRESSOR_CORE_MACROS_SVH

// same-cycle implication
`define NLTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NLTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/nltd_pkg.sv =====
package nltd_pkg;

	typedef enum logic [3:0] {
		PH_HDR,
		PH_WORD,
		PH_LIT,
		PH_LITV,
		PH_OFFLO,
		PH_OFFHI,
		PH_MATV,
		PH_COPY,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		K_BYTE,
		K_TICK,
		K_RESTART,
		K_NONE
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DROP   = 3'd1;
	localparam logic [2:0] ST_BADOFF = 3'd2;
	localparam logic [2:0] ST_SAT    = 3'd3;
	localparam logic [2:0] ST_AFTER  = 3'd4;

	localparam int unsigned LIT_BIAS   = 21;
	localparam int unsigned MATCH_BIAS = 8;
	localparam logic [5:0]  SHIFT_CAP  = 6'd28;
	localparam logic [5:0]  SHIFT_STEP = 6'd7;
	localparam logic [7:0]  PAYLOAD_MASK = 8'h7f;
	localparam logic [3:0]  TAG_VARMATCH = 4'd7;

endpackage

// ===== rtl/core/nltd_front.sv =====
module nltd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,
	input  logic [1:0]     s_tuser,
	output logic           item_valid,
	input  logic           item_ready,
	output nltd_pkg::item_t item
);
	import nltd_pkg::*;

	item_t      q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.data = s_tdata;
		case (s_tuser)
			ACT_BYTE:    cls.kind = K_BYTE;
			ACT_TICK:    cls.kind = K_TICK;
			ACT_RESTART: cls.kind = K_RESTART;
			default:     cls.kind = K_NONE;
		endcase
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = q_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/nltd_back.sv =====
module nltd_back #(
	parameter int unsigned WINDOW_BYTES = 65536,
	parameter int unsigned LENGTH_BITS  = 24,
	parameter int unsigned HEADER_BYTES = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  nltd_pkg::item_t item,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic            m_tuser
);
	import nltd_pkg::*;

	`include "nibble_tagged_lz_decompressor_core_macros.svh"

	localparam int unsigned AW = $clog2(WINDOW_BYTES);
	localparam int unsigned HW = $clog2(HEADER_BYTES + 2);
	localparam int unsigned RW = LENGTH_BITS + 1;
	localparam logic [RW-1:0] MAXV = {1'b0, {LENGTH_BITS{1'b1}}};
	localparam logic [AW:0] WIN = (AW + 1)'(WINDOW_BYTES);
	localparam phase_t PH_START = (HEADER_BYTES == 0) ? PH_WORD : PH_HDR;

	logic [7:0] mem [WINDOW_BYTES];

	phase_t        phase_q, phase_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [AW:0]   bw_q, bw_d;
	logic [HW-1:0] hdr_q, hdr_d;
	logic [31:0]   tag_q, tag_d;
	logic [1:0]    wbc_q, wbc_d;
	logic [4:0]    shift_q, shift_d;
	logic [RW-1:0] rem_q, rem_d;
	logic [15:0]   off_q, off_d;

	logic          advance;
	logic          take;
	logic [7:0]    b;
	logic [6:0]    payload;
	logic [34:0]   wide;
	logic          sat;
	logic          fin;
	logic [RW-1:0] vrem;
	logic [5:0]    vshift_raw;
	logic [4:0]    vshift;
	logic [15:0]   off_hi;
	logic          bad_hi;
	logic          bad_m;
	logic          do_disp;
	logic [31:0]   disp_t;
	logic [AW-1:0] wp_inc;
	logic [16:0]   src_w;

	logic          ovalid_c;
	logic          use_mem_c;
	logic [7:0]    lit_c;
	logic [2:0]    status_c;
	logic [AW-1:0] src_c;

	logic          valid_s2;
	logic          ovalid_s2;
	logic          use_mem_s2;
	logic          byp_s2;
	logic [7:0]    lit_s2;
	logic [AW-1:0] waddr_s2;
	logic          pend_s2;
	logic          done_s2;
	logic [2:0]    status_s2;
	logic [7:0]    rdata_q;
	logic [7:0]    fwd_q;
	logic [7:0]    byte_s2;

	assign advance    = !valid_s2 || m_tready;
	assign item_ready = advance;
	assign take       = item_valid && advance;
	assign b          = item.data;

	// window position wrap and copy source
	assign wp_inc = (32'(wp_q) + 1 >= WINDOW_BYTES) ? '0 : wp_q + 1'b1;
	assign src_w  = 17'(wp_q) + ((17'(wp_q) >= 17'(off_q)) ? 17'd0 : 17'(WINDOW_BYTES))
		- 17'(off_q);

	// varint byte
	assign payload    = 7'(b & PAYLOAD_MASK);
	assign wide       = 35'(payload) << shift_q;
	assign sat        = (payload != 7'd0) &&
		((32'(shift_q) >= LENGTH_BITS) || (wide[34:LENGTH_BITS] != '0));
	assign vrem       = sat ? MAXV : (rem_q | RW'(wide[LENGTH_BITS-1:0]));
	assign fin        = !b[7];
	assign vshift_raw = 6'(shift_q) + SHIFT_STEP;
	assign vshift     = (vshift_raw > SHIFT_CAP) ? 5'(SHIFT_CAP) : vshift_raw[4:0];

	assign off_hi = {b, off_q[7:0]};
	assign bad_hi = (off_hi == 16'd0) || (32'(off_hi) > 32'(bw_q));
	assign bad_m  = (off_q == 16'd0) || (32'(off_q) > 32'(bw_q));

	// next state
	always_comb begin
		phase_d = phase_q;
		wp_d    = wp_q;
		bw_d    = bw_q;
		hdr_d   = hdr_q;
		tag_d   = tag_q;
		wbc_d   = wbc_q;
		shift_d = shift_q;
		rem_d   = rem_q;
		off_d   = off_q;
		do_disp = 1'b0;
		disp_t  = {tag_q[27:0], 4'b0};
		if (take) begin
			case (item.kind)
				K_RESTART: begin
					phase_d = PH_START;
					wp_d    = '0;
					bw_d    = '0;
					hdr_d   = '0;
					tag_d   = '0;
					wbc_d   = '0;
					shift_d = '0;
					rem_d   = '0;
					off_d   = '0;
				end
				K_TICK: begin
					if (phase_q == PH_COPY) begin
						wp_d  = wp_inc;
						bw_d  = (bw_q == WIN) ? bw_q : bw_q + 1'b1;
						rem_d = rem_q - 1'b1;
						if (rem_q == RW'(1)) begin
							do_disp = 1'b1;
						end
					end
				end
				K_BYTE: begin
					case (phase_q)
						PH_HDR: begin
							if (32'(hdr_q) + 1 >= HEADER_BYTES) begin
								hdr_d   = '0;
								phase_d = PH_WORD;
								wbc_d   = '0;
							end else begin
								hdr_d = hdr_q + 1'b1;
							end
						end
						PH_WORD: begin
							tag_d = {tag_q[23:0], b};
							if (wbc_q == 2'd3) begin
								wbc_d = '0;
								if (tag_d == 32'd0) begin
									phase_d = PH_DONE;
								end else begin
									do_disp = 1'b1;
									disp_t  = tag_d;
								end
							end else begin
								wbc_d = wbc_q + 2'd1;
							end
						end
						PH_LIT: begin
							wp_d  = wp_inc;
							bw_d  = (bw_q == WIN) ? bw_q : bw_q + 1'b1;
							rem_d = rem_q - 1'b1;
							if (rem_q == RW'(1)) begin
								do_disp = 1'b1;
							end
						end
						PH_LITV: begin
							rem_d = vrem;
							if (fin) begin
								rem_d   = vrem + RW'(LIT_BIAS);
								phase_d = PH_LIT;
							end else begin
								shift_d = vshift;
							end
						end
						PH_OFFLO: begin
							off_d   = {8'd0, b};
							phase_d = PH_OFFHI;
						end
						PH_OFFHI: begin
							off_d = off_hi;
							if (tag_q[31:28] == TAG_VARMATCH) begin
								rem_d   = '0;
								shift_d = '0;
								phase_d = PH_MATV;
							end else if (bad_hi) begin
								rem_d   = '0;
								do_disp = 1'b1;
							end else begin
								rem_d   = RW'(tag_q[31:28]) + RW'(2);
								phase_d = PH_COPY;
							end
						end
						PH_MATV: begin
							rem_d = vrem;
							if (!fin) begin
								shift_d = vshift;
							end else if (bad_m) begin
								rem_d   = '0;
								do_disp = 1'b1;
							end else begin
								rem_d   = vrem + RW'(MATCH_BIAS);
								phase_d = PH_COPY;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
			if (do_disp) begin
				tag_d = disp_t;
				if (disp_t == 32'd0) begin
					phase_d = PH_WORD;
					wbc_d   = '0;
				end else if (disp_t[31]) begin
					if (disp_t[30:28] != 3'd0) begin
						rem_d   = RW'(disp_t[30:28]);
						phase_d = PH_LIT;
					end else begin
						rem_d   = '0;
						shift_d = '0;
						phase_d = PH_LITV;
					end
				end else begin
					phase_d = PH_OFFLO;
				end
			end
		end
	end

	// per-item result
	always_comb begin
		ovalid_c  = 1'b0;
		use_mem_c = 1'b0;
		lit_c     = 8'd0;
		status_c  = ST_OK;
		src_c     = src_w[AW-1:0];
		case (item.kind)
			K_TICK: begin
				if (phase_q == PH_COPY) begin
					ovalid_c  = 1'b1;
					use_mem_c = 1'b1;
				end
			end
			K_BYTE: begin
				case (phase_q)
					PH_LIT: begin
						ovalid_c = 1'b1;
						lit_c    = b;
					end
					PH_LITV: begin
						if (sat) begin
							status_c = ST_SAT;
						end
					end
					PH_OFFHI: begin
						if (tag_q[31:28] != TAG_VARMATCH && bad_hi) begin
							status_c = ST_BADOFF;
						end
					end
					PH_MATV: begin
						if (fin && bad_m) begin
							status_c = ST_BADOFF;
						end else if (sat) begin
							status_c = ST_SAT;
						end
					end
					PH_COPY:  status_c = ST_DROP;
					PH_DONE:  status_c = ST_AFTER;
					default:  status_c = ST_OK;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign byte_s2 = use_mem_s2 ? (byp_s2 ? fwd_q : rdata_q) : lit_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q <= mem[src_c];
			if (valid_s2 && ovalid_s2) begin
				mem[waddr_s2] <= byte_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_q      <= byte_s2;
			use_mem_s2 <= use_mem_c;
			byp_s2     <= use_mem_c && valid_s2 && ovalid_s2 && (src_c == waddr_s2);
			lit_s2     <= lit_c;
			waddr_s2   <= wp_q;
			ovalid_s2  <= ovalid_c;
			pend_s2    <= (phase_d == PH_COPY);
			done_s2    <= (phase_d == PH_DONE);
			status_s2  <= status_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q  <= PH_START;
			wp_q     <= '0;
			bw_q     <= '0;
			hdr_q    <= '0;
			tag_q    <= '0;
			wbc_q    <= '0;
			shift_q  <= '0;
			rem_q    <= '0;
			off_q    <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= take;
			end
			phase_q <= phase_d;
			wp_q    <= wp_d;
			bw_q    <= bw_d;
			hdr_q   <= hdr_d;
			tag_q   <= tag_d;
			wbc_q   <= wbc_d;
			shift_q <= shift_d;
			rem_q   <= rem_d;
			off_q   <= off_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = ovalid_s2;
	assign m_tdata  = {3'd0, status_s2, done_s2, pend_s2, byte_s2};

	`NLTD_ASSERT_NOW(a_byte_ok, clk, arst_n, valid_s2 && ovalid_s2, status_s2 == ST_OK,
		"byte emitted with nonzero status")
	`NLTD_ASSERT_NOW(a_pend_done, clk, arst_n, valid_s2, !(pend_s2 && done_s2),
		"copy pending after stream end")
	`NLTD_ASSERT_NOW(a_byp_mem, clk, arst_n, valid_s2 && byp_s2, use_mem_s2 && ovalid_s2,
		"bypass on a non-copy transaction")
	`NLTD_ASSERT_NOW(a_bw_range, clk, arst_n, 1'b1, bw_q <= WIN,
		"history fill count beyond window")
	`NLTD_ASSERT_NEXT(a_restart, clk, arst_n, take && item.kind == K_RESTART,
		bw_q == '0 && phase_q == PH_START, "restart did not clear decoder")

endmodule

// ===== rtl/core/nibble_tagged_lz_decompressor_core.sv =====
// each input transaction passes through the input queue, then is decoded into the output register
// throughput: one transaction per cycle while m_tready stays high, compressed byte or copy tick alike
// the history window is one read and one write port; a self-overlapping copy is forwarded
// from the output register, so back-to-back ticks keep full rate
// reset: arst_n clears queue, decoder state and output valid; history contents stay undefined
module nibble_tagged_lz_decompressor_core #(
	parameter int unsigned WINDOW_BYTES = 65536,
	parameter int unsigned LENGTH_BITS  = 24,
	parameter int unsigned HEADER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // in_byte
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte, copy_pending, stream_done, status, zero pad
	output logic        m_tuser   // out_valid
);
	import nltd_pkg::*;

	logic  item_valid;
	logic  item_ready;
	item_t item;

	nltd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	nltd_back #(
		.WINDOW_BYTES (WINDOW_BYTES),
		.LENGTH_BITS  (LENGTH_BITS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== sim/nibble_tagged_lz_decompressor_core_checker.sv =====
module nibble_tagged_lz_decompressor_core_checker #(
	parameter int unsigned WINDOW_BYTES = 65536,
	parameter int unsigned LENGTH_BITS  = 24,
	parameter int unsigned HEADER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          outstanding
);
	import nltd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       pending;
		logic       done;
		logic [2:0] status;
	} outcome_t;

	outcome_t   expected_outcomes[$];
	logic [7:0] window_mem [WINDOW_BYTES];
	logic [15:0] wr_pos;
	logic [16:0] written;
	phase_t      ph;
	logic [4:0]  hdr_cnt;
	logic [31:0] tags;
	logic [1:0]  word_cnt;
	logic [4:0]  shift;
	logic [24:0] remaining;
	logic [15:0] offset;

	localparam logic [24:0] LEN_MAX = 25'((64'd1 << LENGTH_BITS) - 1);

	initial fail_count = 0;
	assign outstanding = expected_outcomes.size();

	task automatic clear_decoder();
		wr_pos = '0;
		written = '0;
		hdr_cnt = '0;
		tags = '0;
		word_cnt = '0;
		shift = '0;
		remaining = '0;
		offset = '0;
		ph = (HEADER_BYTES == 0) ? PH_WORD : PH_HDR;
	endtask

	task automatic record_byte(input logic [7:0] b);
		window_mem[wr_pos] = b;
		wr_pos = (32'(wr_pos) + 1 >= WINDOW_BYTES) ? '0 : wr_pos + 1'b1;
		if (written < WINDOW_BYTES)
			written++;
	endtask

	task automatic dispatch();
		logic [3:0] t;
		if (tags == 0) begin
			ph = PH_WORD;
			word_cnt = '0;
		end else begin
			t = tags[31:28];
			if (t[3]) begin
				if (t[2:0] != 0) begin
					remaining = 25'(t[2:0]);
					ph = PH_LIT;
				end else begin
					remaining = '0;
					shift = '0;
					ph = PH_LITV;
				end
			end else begin
				ph = PH_OFFLO;
			end
		end
	endtask

	task automatic advance_tag();
		tags = tags << 4;
		dispatch();
	endtask

	task automatic begin_copy(input logic [24:0] len, output logic bad);
		bad = (offset == 0) || (17'(offset) > written);
		if (bad) begin
			remaining = '0;
			advance_tag();
		end else begin
			remaining = len;
			ph = PH_COPY;
		end
	endtask

	task automatic take_length_byte(input logic [7:0] b, output logic sat, output logic fin);
		logic [63:0] wide;
		sat = 1'b0;
		if ((b & PAYLOAD_MASK) != 0) begin
			if (shift >= LENGTH_BITS) begin
				sat = 1'b1;
			end else begin
				wide = 64'(b & PAYLOAD_MASK) << shift;
				if (wide > 64'(LEN_MAX))
					sat = 1'b1;
				else
					remaining |= 25'(wide);
			end
		end
		if (sat)
			remaining = LEN_MAX;
		fin = !b[7];
		if (!fin) begin
			if (32'(shift) + 7 > 28)
				shift = 5'(SHIFT_CAP);
			else
				shift = shift + 5'(SHIFT_STEP);
		end
	endtask

	task automatic predict_outcome(input logic [1:0] act, input logic [7:0] b,
			output outcome_t o);
		logic sat, fin, bad;
		logic [7:0] v;
		o = '0;
		if (act == ACT_RESTART) begin
			clear_decoder();
			return;
		end
		if (act == ACT_TICK) begin
			if (ph == PH_COPY) begin
				v = window_mem[(32'(wr_pos) + WINDOW_BYTES - 32'(offset)) % WINDOW_BYTES];
				o.data = v;
				o.valid = 1'b1;
				record_byte(v);
				remaining--;
				if (remaining == 0)
					advance_tag();
			end
		end else if (act == ACT_BYTE) begin
			case (ph)
				PH_HDR: begin
					hdr_cnt++;
					if (hdr_cnt >= HEADER_BYTES) begin
						hdr_cnt = '0;
						ph = PH_WORD;
						word_cnt = '0;
					end
				end
				PH_WORD: begin
					tags = {tags[23:0], b};
					if (word_cnt == 2'd3) begin
						word_cnt = '0;
						if (tags == 0)
							ph = PH_DONE;
						else
							dispatch();
					end else begin
						word_cnt++;
					end
				end
				PH_LIT: begin
					o.data = b;
					o.valid = 1'b1;
					record_byte(b);
					remaining--;
					if (remaining == 0)
						advance_tag();
				end
				PH_LITV: begin
					take_length_byte(b, sat, fin);
					if (sat)
						o.status = ST_SAT;
					if (fin) begin
						remaining = remaining + 25'(LIT_BIAS);
						ph = PH_LIT;
					end
				end
				PH_OFFLO: begin
					offset = {8'h00, b};
					ph = PH_OFFHI;
				end
				PH_OFFHI: begin
					offset[15:8] = b;
					if (tags[31:28] == TAG_VARMATCH) begin
						remaining = '0;
						shift = '0;
						ph = PH_MATV;
					end else begin
						begin_copy(25'(tags[31:28]) + 25'd2, bad);
						if (bad)
							o.status = ST_BADOFF;
					end
				end
				PH_MATV: begin
					take_length_byte(b, sat, fin);
					if (sat)
						o.status = ST_SAT;
					if (fin) begin
						begin_copy(remaining + 25'(MATCH_BIAS), bad);
						if (bad)
							o.status = ST_BADOFF;
					end
				end
				PH_COPY: o.status = ST_DROP;
				default: o.status = ST_AFTER;
			endcase
		end
		o.pending = (ph == PH_COPY);
		o.done = (ph == PH_DONE);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial clear_decoder();

	always @(posedge clk) begin
		outcome_t o, got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_outcome(s_tuser, s_tdata, o);
				expected_outcomes.push_back(o);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tuser, m_tdata[8], m_tdata[9], m_tdata[12:10]};
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					o = expected_outcomes.pop_front();
					if (got.data !== o.data)
						report_mismatch($sformatf("out_byte %h, want %h", got.data, o.data));
					if (got.valid !== o.valid)
						report_mismatch($sformatf("out_valid %b, want %b", got.valid, o.valid));
					if (got.pending !== o.pending)
						report_mismatch($sformatf("copy_pending %b, want %b",
							got.pending, o.pending));
					if (got.done !== o.done)
						report_mismatch($sformatf("stream_done %b, want %b", got.done, o.done));
					if (got.status !== o.status)
						report_mismatch($sformatf("status %0d, want %0d", got.status, o.status));
					if (m_tdata[15:13] !== 3'b000)
						report_mismatch("nonzero pad bits");
				end
			end
		end
	end

endmodule

// ===== sim/nibble_tagged_lz_decompressor_core_test.sv =====
module nibble_tagged_lz_decompressor_core_test;
	import nltd_pkg::*;

	localparam int HEADER_BYTES_TB = 12;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	int          fail_count;
	int          outstanding;
	int          idle_pct;
	int          stall_pct;
	int          sent;
	int unsigned produced;

	nibble_tagged_lz_decompressor_core dut (.*);

	nibble_tagged_lz_decompressor_core_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	initial begin
		#(12 * 3000000);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send(input logic [1:0] act, input logic [7:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_literals(input int n);
		for (int i = 0; i < n; i++) begin
			send(ACT_BYTE, 8'($urandom));
			if (produced < 65535)
				produced++;
		end
	endtask

	// ticks for a copy, with stray bytes and unused actions mixed in
	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				send(ACT_BYTE, 8'($urandom));
			if ($urandom_range(39) == 0)
				send(2'($urandom_range(3, 3)), 8'($urandom));
			send(ACT_TICK, 8'($urandom));
			if (produced < 65535)
				produced++;
		end
	endtask

	// one stream with random content, including some invalid match offsets; returns early after a saturated length
	task automatic send_stream();
		logic [31:0] word;
		logic [3:0]  t;
		logic [15:0] ofs;
		int          len;
		int          v;
		int          words;
		send(ACT_RESTART, 8'($urandom));
		produced = 0;
		for (int i = 0; i < HEADER_BYTES_TB; i++)
			send(ACT_BYTE, 8'($urandom));
		words = $urandom_range(1, 4);
		for (int w = 0; w < words; w++) begin
			word = $urandom;
			if (w == 0)
				word[31] = 1'b1;
			if (word == 0)
				word = 32'h9000_0000;
			for (int b = 3; b >= 0; b--)
				send(ACT_BYTE, word[b*8 +: 8]);
			for (int n = 0; n < 8; n++) begin
				if ((word << (4 * n)) == 0)
					break;
				t = word[31 - 4*n -: 4];
				if (t[3]) begin
					len = t[2:0];
					if (len == 0) begin
						if ($urandom_range(29) == 0) begin
							send(ACT_BYTE, 8'hff); send(ACT_BYTE, 8'hff);
							send(ACT_BYTE, 8'hff); send(ACT_BYTE, 8'hff);
							send(ACT_BYTE, 8'h7f);
							send_literals(3);
							return;
						end
						v = $urandom_range(0, 20);
						if ($urandom_range(3) == 0) begin
							send(ACT_BYTE, 8'h80 | 8'(v));
							send(ACT_BYTE, 8'h00);
						end else begin
							send(ACT_BYTE, 8'(v));
						end
						len = v + 21;
					end
					send_literals(len);
				end else begin
					if ($urandom_range(9) == 0 || produced == 0)
						ofs = $urandom_range(1) ? 16'h0000 : 16'(produced + 1);
					else
						ofs = 16'($urandom_range(1, produced));
					send(ACT_BYTE, ofs[7:0]);
					send(ACT_BYTE, ofs[15:8]);
					len = t + 2;
					if (t == TAG_VARMATCH) begin
						if ($urandom_range(29) == 0) begin
							send(ACT_BYTE, 8'hff); send(ACT_BYTE, 8'hff);
							send(ACT_BYTE, 8'hff); send(ACT_BYTE, 8'hff);
							send(ACT_BYTE, 8'h01);
							send_ticks(2);
							return;
						end
						v = $urandom_range(0, 20);
						send(ACT_BYTE, 8'(v));
						len = v + 8;
					end
					if (ofs != 0 && ofs <= produced)
						send_ticks(len);
				end
			end
		end
		if ($urandom_range(1)) begin
			repeat (4) send(ACT_BYTE, 8'h00);
			send(ACT_BYTE, 8'($urandom));
			send(ACT_TICK, 8'($urandom));
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_BYTE;
		m_tready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		produced = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle actions, header extremes, literal, overlapping match
		send(2'($urandom_range(3, 3)), 8'hff);
		send(ACT_TICK, 8'h00);
		for (int i = 0; i < HEADER_BYTES_TB; i++)
			send(ACT_BYTE, i[0] ? 8'hff : 8'h00);
		send(ACT_BYTE, 8'h97); send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h00); send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'hff);
		send(ACT_BYTE, 8'h01); send(ACT_BYTE, 8'h00); send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h5a);
		repeat (8) send(ACT_TICK, 8'hff);
		send(ACT_BYTE, 8'h00);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 57; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 57; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			sent = 0;
			while (sent < 280)
				send_stream();
		end
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
